@@ hdl/wav_riff_chunk_parser_assert.svh @@
// Assertion macros used by the parser core (wrp_core).
// Each macro expects clk_i and rst_ni in scope.
`ifndef WAV_RIFF_CHUNK_PARSER_ASSERT_SVH
`define WAV_RIFF_CHUNK_PARSER_ASSERT_SVH

// Same-cycle implication.
`define WRP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("parser assertion failed");

// Next-cycle implication.
`define WRP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("parser assertion failed");

`endif

@@ hdl/wrp_pkg.sv @@
`default_nettype none

package wrp_pkg;

  typedef enum logic [6:0] {
    PH_HEADER = 7'b0000001,
    PH_CHDR   = 7'b0000010,
    PH_FMT    = 7'b0000100,
    PH_DATA   = 7'b0001000,
    PH_SKIP   = 7'b0010000,
    PH_PAD    = 7'b0100000,
    PH_DONE   = 7'b1000000
  } wrp_phase_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_HEADER = 3'd1,
    ST_NO_FMT     = 3'd2,
    ST_NO_DATA    = 3'd3,
    ST_NOT_PCM    = 3'd4
  } wrp_status_e;

  localparam logic [31:0] TAG_FMT  = 32'h666D7420;
  localparam logic [31:0] TAG_DATA = 32'h64617461;
  localparam logic [15:0] FORMAT_PCM = 16'd1;
  localparam logic [15:0] BITS_U8    = 16'd8;

  localparam logic [7:0] RIFF_MAGIC [4] = '{8'h52, 8'h49, 8'h46, 8'h46};
  localparam logic [7:0] WAVE_MAGIC [4] = '{8'h57, 8'h41, 8'h56, 8'h45};

  localparam logic [3:0] HDR_LAST_POS  = 4'd11;
  localparam logic [3:0] CHDR_LAST_POS = 4'd7;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        is_payload;
    logic        summary_valid;
    wrp_status_e status;
    logic [15:0] format_code;
    logic [15:0] channel_count;
    logic [31:0] rate_hz;
    logic [15:0] sample_bits;
    logic        is_u8;
    logic [31:0] payload_length;
  } wrp_result_t;

endpackage

`default_nettype wire

@@ hdl/wrp_in_stage.sv @@
`default_nettype none

module wrp_in_stage (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       final_byte_i,
  input  wire logic       down_ready_i,
  output logic            take_o,
  output logic [7:0]      byte_o,
  output logic            final_o
);

  logic       valid_q;
  logic [7:0] byte_q;
  logic       final_q;

  assign take_o     = valid_q && down_ready_i;
  assign in_ready_o = !valid_q || take_o;
  assign byte_o     = byte_q;
  assign final_o    = final_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Payload needs no reset; load whenever the slot frees up.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q  <= in_byte_i;
      final_q <= final_byte_i;
    end
  end

endmodule

`default_nettype wire

@@ hdl/wrp_core.sv @@
`default_nettype none

`include "wav_riff_chunk_parser_assert.svh"

module wrp_core (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         adv_i,
  input  wire logic [7:0]   byte_i,
  input  wire logic         fin_i,
  output wrp_pkg::wrp_result_t res_o
);
  import wrp_pkg::*;

  wrp_phase_e  phase_q, phase_d;
  logic [3:0]  byte_pos_q, byte_pos_d;
  logic [31:0] tag_q, tag_d;
  logic [31:0] length_q, length_d;
  logic [31:0] bytes_left_q, bytes_left_d;
  logic        pad_q, pad_d;
  logic [4:0]  fmt_off_q, fmt_off_d;
  logic [15:0] held_format_q, held_format_d;
  logic [15:0] held_channels_q, held_channels_d;
  logic [31:0] held_rate_q, held_rate_d;
  logic [15:0] held_bits_q, held_bits_d;
  logic [31:0] held_length_q, held_length_d;
  logic        seen_fmt_q, seen_fmt_d;
  logic        seen_data_q, seen_data_d;
  logic        header_bad_q, header_bad_d;
  logic [15:0] cap_format_q, cap_format_d;
  logic [15:0] cap_channels_q, cap_channels_d;
  logic [31:0] cap_rate_q, cap_rate_d;
  logic [15:0] cap_bits_q, cap_bits_d;

  logic [31:0] left_dec;
  wrp_status_e status;

  function automatic wrp_phase_e end_phase(logic sf, logic sd, logic pp);
    wrp_phase_e ph;
    if (sf && sd) begin
      ph = PH_DONE;
    end else if (pp) begin
      ph = PH_PAD;
    end else begin
      ph = PH_CHDR;
    end
    return ph;
  endfunction

  assign left_dec = bytes_left_q - 32'd1;

  always_comb begin
    phase_d         = phase_q;
    byte_pos_d      = byte_pos_q;
    tag_d           = tag_q;
    length_d        = length_q;
    bytes_left_d    = bytes_left_q;
    pad_d           = pad_q;
    fmt_off_d       = fmt_off_q;
    held_format_d   = held_format_q;
    held_channels_d = held_channels_q;
    held_rate_d     = held_rate_q;
    held_bits_d     = held_bits_q;
    held_length_d   = held_length_q;
    seen_fmt_d      = seen_fmt_q;
    seen_data_d     = seen_data_q;
    header_bad_d    = header_bad_q;
    cap_format_d    = cap_format_q;
    cap_channels_d  = cap_channels_q;
    cap_rate_d      = cap_rate_q;
    cap_bits_d      = cap_bits_q;
    status          = ST_OK;

    res_o                = '0;
    res_o.payload_byte   = byte_i;
    res_o.summary_valid  = fin_i;

    unique case (phase_q)
      PH_HEADER: begin
        if (byte_pos_q < 4'd4) begin
          if (byte_i != RIFF_MAGIC[byte_pos_q[1:0]]) header_bad_d = 1'b1;
        end else if (byte_pos_q >= 4'd8) begin
          if (byte_i != WAVE_MAGIC[byte_pos_q[1:0]]) header_bad_d = 1'b1;
        end
        if (byte_pos_q >= HDR_LAST_POS) begin
          byte_pos_d = '0;
          phase_d    = header_bad_d ? PH_DONE : PH_CHDR;
        end else begin
          byte_pos_d = byte_pos_q + 4'd1;
        end
      end
      PH_CHDR: begin
        if (byte_pos_q < 4'd4) begin
          tag_d = {tag_q[23:0], byte_i};
        end else begin
          length_d = {byte_i, length_q[31:8]};
        end
        if (byte_pos_q >= CHDR_LAST_POS) begin
          byte_pos_d   = '0;
          pad_d        = length_d[0];
          bytes_left_d = length_d;
          if (tag_d == TAG_FMT) begin
            cap_format_d   = '0;
            cap_channels_d = '0;
            cap_rate_d     = '0;
            cap_bits_d     = '0;
            fmt_off_d      = '0;
            if (length_d == '0) begin
              held_format_d   = '0;
              held_channels_d = '0;
              held_rate_d     = '0;
              held_bits_d     = '0;
              seen_fmt_d      = 1'b1;
              phase_d         = end_phase(1'b1, seen_data_q, pad_d);
            end else begin
              phase_d = PH_FMT;
            end
          end else if (tag_d == TAG_DATA) begin
            held_length_d = length_d;
            if (length_d == '0) begin
              seen_data_d = 1'b1;
              phase_d     = end_phase(seen_fmt_q, 1'b1, pad_d);
            end else begin
              phase_d = PH_DATA;
            end
          end else begin
            if (length_d == '0) begin
              phase_d = end_phase(seen_fmt_q, seen_data_q, pad_d);
            end else begin
              phase_d = PH_SKIP;
            end
          end
        end else begin
          byte_pos_d = byte_pos_q + 4'd1;
        end
      end
      PH_FMT: begin
        // Offsets past the bits-per-sample field are dropped.
        if (!fmt_off_q[4]) begin
          if (fmt_off_q < 5'd2) begin
            cap_format_d[{fmt_off_q[0], 3'b000} +: 8] = byte_i;
          end else if (fmt_off_q < 5'd4) begin
            cap_channels_d[{fmt_off_q[0], 3'b000} +: 8] = byte_i;
          end else if (fmt_off_q < 5'd8) begin
            cap_rate_d[{fmt_off_q[1:0], 3'b000} +: 8] = byte_i;
          end else if (fmt_off_q >= 5'd14) begin
            cap_bits_d[{fmt_off_q[0], 3'b000} +: 8] = byte_i;
          end
          fmt_off_d = fmt_off_q + 5'd1;
        end
        bytes_left_d = left_dec;
        if (left_dec == '0) begin
          held_format_d   = cap_format_d;
          held_channels_d = cap_channels_d;
          held_rate_d     = cap_rate_d;
          held_bits_d     = cap_bits_d;
          seen_fmt_d      = 1'b1;
          phase_d         = end_phase(1'b1, seen_data_q, pad_q);
        end
      end
      PH_DATA: begin
        res_o.is_payload = 1'b1;
        bytes_left_d     = left_dec;
        if (left_dec == '0) begin
          seen_data_d = 1'b1;
          phase_d     = end_phase(seen_fmt_q, 1'b1, pad_q);
        end
      end
      PH_SKIP: begin
        bytes_left_d = left_dec;
        if (left_dec == '0) begin
          phase_d = end_phase(seen_fmt_q, seen_data_q, pad_q);
        end
      end
      PH_PAD: begin
        pad_d   = 1'b0;
        phase_d = PH_CHDR;
      end
      PH_DONE: begin
      end
      default: begin
      end
    endcase

    if (header_bad_d || phase_d == PH_HEADER) begin
      status = ST_BAD_HEADER;
    end else if (!seen_fmt_d) begin
      status = ST_NO_FMT;
    end else if (!seen_data_d || phase_d == PH_DATA) begin
      status = ST_NO_DATA;
    end else if (held_format_d != FORMAT_PCM) begin
      status = ST_NOT_PCM;
    end

    if (fin_i) begin
      res_o.status         = status;
      res_o.format_code    = held_format_d;
      res_o.channel_count  = held_channels_d;
      res_o.rate_hz        = held_rate_d;
      res_o.sample_bits    = held_bits_d;
      res_o.is_u8          = (held_bits_d == BITS_U8);
      res_o.payload_length = held_length_d;

      // Restart for the next file.
      phase_d         = PH_HEADER;
      byte_pos_d      = '0;
      tag_d           = '0;
      length_d        = '0;
      bytes_left_d    = '0;
      pad_d           = 1'b0;
      fmt_off_d       = '0;
      held_format_d   = '0;
      held_channels_d = '0;
      held_rate_d     = '0;
      held_bits_d     = '0;
      held_length_d   = '0;
      seen_fmt_d      = 1'b0;
      seen_data_d     = 1'b0;
      header_bad_d    = 1'b0;
      cap_format_d    = '0;
      cap_channels_d  = '0;
      cap_rate_d      = '0;
      cap_bits_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PH_HEADER;
      byte_pos_q      <= '0;
      tag_q           <= '0;
      length_q        <= '0;
      bytes_left_q    <= '0;
      pad_q           <= 1'b0;
      fmt_off_q       <= '0;
      held_format_q   <= '0;
      held_channels_q <= '0;
      held_rate_q     <= '0;
      held_bits_q     <= '0;
      held_length_q   <= '0;
      seen_fmt_q      <= 1'b0;
      seen_data_q     <= 1'b0;
      header_bad_q    <= 1'b0;
      cap_format_q    <= '0;
      cap_channels_q  <= '0;
      cap_rate_q      <= '0;
      cap_bits_q      <= '0;
    end else if (adv_i) begin
      phase_q         <= phase_d;
      byte_pos_q      <= byte_pos_d;
      tag_q           <= tag_d;
      length_q        <= length_d;
      bytes_left_q    <= bytes_left_d;
      pad_q           <= pad_d;
      fmt_off_q       <= fmt_off_d;
      held_format_q   <= held_format_d;
      held_channels_q <= held_channels_d;
      held_rate_q     <= held_rate_d;
      held_bits_q     <= held_bits_d;
      held_length_q   <= held_length_d;
      seen_fmt_q      <= seen_fmt_d;
      seen_data_q     <= seen_data_d;
      header_bad_q    <= header_bad_d;
      cap_format_q    <= cap_format_d;
      cap_channels_q  <= cap_channels_d;
      cap_rate_q      <= cap_rate_d;
      cap_bits_q      <= cap_bits_d;
    end
  end

  `WRP_ASSERT_NEXT(a_fin_restarts, adv_i && fin_i, phase_q == PH_HEADER && byte_pos_q == '0)
  `WRP_ASSERT_NEXT(a_idle_holds, !adv_i, $stable(phase_q) && $stable(bytes_left_q))
  `WRP_ASSERT_NEXT(a_pad_to_chdr, adv_i && !fin_i && phase_q == PH_PAD, phase_q == PH_CHDR && !pad_q)
  `WRP_ASSERT_IMPL(a_body_nonempty, phase_q == PH_FMT || phase_q == PH_DATA || phase_q == PH_SKIP, bytes_left_q != '0)

endmodule

`default_nettype wire

@@ hdl/wrp_out_stage.sv @@
`default_nettype none

module wrp_out_stage (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         load_i,
  input  wire wrp_pkg::wrp_result_t res_i,
  output logic              up_ready_o,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output wrp_pkg::wrp_result_t res_o
);
  import wrp_pkg::*;

  logic        valid_q;
  wrp_result_t res_q;

  assign up_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (up_ready_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

`default_nettype wire

@@ hdl/wav_riff_chunk_parser.sv @@
// Channel | Handshake                 | Fields
// --------+---------------------------+---------------------------------------
// in      | in_valid_i / in_ready_o   | in_byte_i, final_byte_i
// out     | out_valid_o / out_ready_i | payload_byte_o .. payload_length_o
//
// One item per cycle sustained while out_ready_i stays high; each accepted item
// passes the input register, then parse logic into the result register.
// rst_ni clears the parser to the header phase and empties both registers.
// A stalled output holds its item; the input register then fills and
// in_ready_o drops until out_ready_i returns.
`default_nettype none

module wav_riff_chunk_parser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  in_byte_i,
  input  wire logic        final_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       payload_byte_o,
  output logic             is_payload_o,
  output logic             summary_valid_o,
  output logic [2:0]       status_o,
  output logic [15:0]      format_code_o,
  output logic [15:0]      channel_count_o,
  output logic [31:0]      rate_hz_o,
  output logic [15:0]      sample_bits_o,
  output logic             is_u8_o,
  output logic [31:0]      payload_length_o
);
  import wrp_pkg::*;

  logic        up_ready;
  logic        take;
  logic [7:0]  byte_s;
  logic        fin_s;
  wrp_result_t res_comb;
  wrp_result_t res_reg;

  wrp_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_byte_i    (in_byte_i),
    .final_byte_i (final_byte_i),
    .down_ready_i (up_ready),
    .take_o       (take),
    .byte_o       (byte_s),
    .final_o      (fin_s)
  );

  wrp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (take),
    .byte_i (byte_s),
    .fin_i  (fin_s),
    .res_o  (res_comb)
  );

  wrp_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take),
    .res_i       (res_comb),
    .up_ready_o  (up_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_reg)
  );

  assign payload_byte_o   = res_reg.payload_byte;
  assign is_payload_o     = res_reg.is_payload;
  assign summary_valid_o  = res_reg.summary_valid;
  assign status_o         = res_reg.status;
  assign format_code_o    = res_reg.format_code;
  assign channel_count_o  = res_reg.channel_count;
  assign rate_hz_o        = res_reg.rate_hz;
  assign sample_bits_o    = res_reg.sample_bits;
  assign is_u8_o          = res_reg.is_u8;
  assign payload_length_o = res_reg.payload_length;

endmodule

`default_nettype wire

@@ tb/wav_riff_chunk_parser_test.sv @@
`timescale 1ns / 1ps

module wav_riff_chunk_parser_test;
  import wrp_pkg::*;

  localparam int RANDOM_BYTES = 300;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 10;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  in_byte_i;
  logic        final_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  payload_byte_o;
  logic        is_payload_o;
  logic        summary_valid_o;
  logic [2:0]  status_o;
  logic [15:0] format_code_o;
  logic [15:0] channel_count_o;
  logic [31:0] rate_hz_o;
  logic [15:0] sample_bits_o;
  logic        is_u8_o;
  logic [31:0] payload_length_o;

  wav_riff_chunk_parser dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .in_byte_i       (in_byte_i),
    .final_byte_i    (final_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .payload_byte_o  (payload_byte_o),
    .is_payload_o    (is_payload_o),
    .summary_valid_o (summary_valid_o),
    .status_o        (status_o),
    .format_code_o   (format_code_o),
    .channel_count_o (channel_count_o),
    .rate_hz_o       (rate_hz_o),
    .sample_bits_o   (sample_bits_o),
    .is_u8_o         (is_u8_o),
    .payload_length_o(payload_length_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Parser state as the block should hold it
  wrp_phase_e  ps_phase;
  logic [3:0]  ps_pos;
  logic [31:0] ps_tag;
  logic [31:0] ps_len;
  logic [31:0] ps_left;
  logic        ps_pad;
  logic [4:0]  ps_fmt_idx;
  logic [15:0] ps_format;
  logic [15:0] ps_channels;
  logic [31:0] ps_rate;
  logic [15:0] ps_bits;
  logic [31:0] ps_length;
  logic        ps_have_fmt;
  logic        ps_have_data;
  logic        ps_bad_hdr;
  logic [15:0] cap_format;
  logic [15:0] cap_channels;
  logic [31:0] cap_rate;
  logic [15:0] cap_bits;

  wrp_result_t predicted_out_q[$];
  logic [7:0]  file_q[$];
  int          error_count = 0;
  int          idle_cycles = 0;
  int          stall_left = 0;
  bit          allow_gaps = 1'b1;

  function automatic void clear_parser();
    ps_phase     = PH_HEADER;
    ps_pos       = '0;
    ps_tag       = '0;
    ps_len       = '0;
    ps_left      = '0;
    ps_pad       = 1'b0;
    ps_fmt_idx   = '0;
    ps_format    = '0;
    ps_channels  = '0;
    ps_rate      = '0;
    ps_bits      = '0;
    ps_length    = '0;
    ps_have_fmt  = 1'b0;
    ps_have_data = 1'b0;
    ps_bad_hdr   = 1'b0;
    cap_format   = '0;
    cap_channels = '0;
    cap_rate     = '0;
    cap_bits     = '0;
  endfunction

  function automatic void close_chunk();
    if (ps_have_fmt && ps_have_data) begin
      ps_phase = PH_DONE;
    end else if (ps_pad) begin
      ps_phase = PH_PAD;
    end else begin
      ps_phase = PH_CHDR;
    end
  endfunction

  function automatic void commit_fmt();
    ps_format   = cap_format;
    ps_channels = cap_channels;
    ps_rate     = cap_rate;
    ps_bits     = cap_bits;
    ps_have_fmt = 1'b1;
    close_chunk();
  endfunction

  function automatic void open_chunk();
    ps_pad  = ps_len[0];
    ps_left = ps_len;
    if (ps_tag == TAG_FMT) begin
      cap_format   = '0;
      cap_channels = '0;
      cap_rate     = '0;
      cap_bits     = '0;
      ps_fmt_idx   = '0;
      if (ps_len == 0) begin
        commit_fmt();
      end else begin
        ps_phase = PH_FMT;
      end
    end else if (ps_tag == TAG_DATA) begin
      ps_length = ps_len;
      if (ps_len == 0) begin
        ps_have_data = 1'b1;
        close_chunk();
      end else begin
        ps_phase = PH_DATA;
      end
    end else if (ps_len == 0) begin
      close_chunk();
    end else begin
      ps_phase = PH_SKIP;
    end
  endfunction

  // Bytes past offset 15 of a fmt body carry nothing we keep
  function automatic void take_fmt_byte(input logic [7:0] b);
    if (ps_fmt_idx < 16) begin
      case (ps_fmt_idx[3:0])
        4'd0:  cap_format[7:0]    = b;
        4'd1:  cap_format[15:8]   = b;
        4'd2:  cap_channels[7:0]  = b;
        4'd3:  cap_channels[15:8] = b;
        4'd4:  cap_rate[7:0]      = b;
        4'd5:  cap_rate[15:8]     = b;
        4'd6:  cap_rate[23:16]    = b;
        4'd7:  cap_rate[31:24]    = b;
        4'd14: cap_bits[7:0]      = b;
        4'd15: cap_bits[15:8]     = b;
        default: ;
      endcase
      ps_fmt_idx = ps_fmt_idx + 5'd1;
    end
  endfunction

  function automatic void advance_parser(input logic [7:0] b, input logic fin);
    wrp_result_t r;
    r = '0;
    r.payload_byte = b;
    case (ps_phase)
      PH_HEADER: begin
        if (ps_pos < 4) begin
          if (b != RIFF_MAGIC[ps_pos[1:0]]) ps_bad_hdr = 1'b1;
        end else if (ps_pos >= 8) begin
          if (b != WAVE_MAGIC[ps_pos[1:0]]) ps_bad_hdr = 1'b1;
        end
        if (ps_pos >= HDR_LAST_POS) begin
          ps_pos = '0;
          if (ps_bad_hdr) begin
            ps_phase = PH_DONE;
          end else begin
            ps_phase = PH_CHDR;
          end
        end else begin
          ps_pos = ps_pos + 4'd1;
        end
      end
      PH_CHDR: begin
        if (ps_pos < 4) begin
          ps_tag = {ps_tag[23:0], b};
        end else begin
          ps_len = {b, ps_len[31:8]};
        end
        if (ps_pos >= CHDR_LAST_POS) begin
          ps_pos = '0;
          open_chunk();
        end else begin
          ps_pos = ps_pos + 4'd1;
        end
      end
      PH_FMT: begin
        take_fmt_byte(b);
        ps_left = ps_left - 32'd1;
        if (ps_left == 0) commit_fmt();
      end
      PH_DATA: begin
        r.is_payload = 1'b1;
        ps_left = ps_left - 32'd1;
        if (ps_left == 0) begin
          ps_have_data = 1'b1;
          close_chunk();
        end
      end
      PH_SKIP: begin
        ps_left = ps_left - 32'd1;
        if (ps_left == 0) close_chunk();
      end
      PH_PAD: begin
        ps_pad   = 1'b0;
        ps_phase = PH_CHDR;
      end
      default: ;
    endcase
    if (fin) begin
      r.summary_valid = 1'b1;
      if (ps_bad_hdr || ps_phase == PH_HEADER) begin
        r.status = ST_BAD_HEADER;
      end else if (!ps_have_fmt) begin
        r.status = ST_NO_FMT;
      end else if (!ps_have_data || ps_phase == PH_DATA) begin
        r.status = ST_NO_DATA;
      end else if (ps_format != FORMAT_PCM) begin
        r.status = ST_NOT_PCM;
      end else begin
        r.status = ST_OK;
      end
      r.format_code    = ps_format;
      r.channel_count  = ps_channels;
      r.rate_hz        = ps_rate;
      r.sample_bits    = ps_bits;
      r.is_u8          = (ps_bits == BITS_U8);
      r.payload_length = ps_length;
      clear_parser();
    end
    predicted_out_q.push_back(r);
  endfunction

  function automatic int pick_gap();
    int roll;
    if (!allow_gaps) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i   = 1'b1;
    in_byte_i    = b;
    final_byte_i = fin;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    advance_parser(b, fin);
  endtask

  // Send the assembled file, flagging its last byte
  task automatic send_file();
    int i;
    for (i = 0; i < file_q.size(); i++) begin
      send_byte(file_q[i], i == file_q.size() - 1);
    end
    file_q.delete();
  endtask

  function automatic void push_le(input logic [31:0] v, input int n);
    int i;
    for (i = 0; i < n; i++) file_q.push_back(v[8*i +: 8]);
  endfunction

  function automatic void push_tag(input logic [31:0] tag);
    file_q.push_back(tag[31:24]);
    file_q.push_back(tag[23:16]);
    file_q.push_back(tag[15:8]);
    file_q.push_back(tag[7:0]);
  endfunction

  function automatic void push_riff_header();
    int i;
    for (i = 0; i < 4; i++) file_q.push_back(RIFF_MAGIC[i]);
    push_le($urandom, 4);
    for (i = 0; i < 4; i++) file_q.push_back(WAVE_MAGIC[i]);
  endfunction

  function automatic void push_body(input logic [31:0] size);
    int i;
    for (i = 0; i < size; i++) file_q.push_back(8'($urandom_range(0, 255)));
    if (size[0]) file_q.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void push_chunk(input logic [31:0] tag, input logic [31:0] size);
    push_tag(tag);
    push_le(size, 4);
    push_body(size);
  endfunction

  function automatic void push_fmt(input logic [31:0] size, input logic [15:0] code,
                                   input logic [15:0] chans, input logic [31:0] rate,
                                   input logic [15:0] bits);
    logic [7:0] body [16];
    int i;
    body[0] = code[7:0];
    body[1] = code[15:8];
    body[2] = chans[7:0];
    body[3] = chans[15:8];
    for (i = 0; i < 4; i++) body[4 + i] = rate[8*i +: 8];
    for (i = 8; i < 14; i++) body[i] = 8'($urandom_range(0, 255));
    body[14] = bits[7:0];
    body[15] = bits[15:8];
    push_tag(TAG_FMT);
    push_le(size, 4);
    for (i = 0; i < size; i++) begin
      file_q.push_back(i < 16 ? body[i] : 8'($urandom_range(0, 255)));
    end
    if (size[0]) file_q.push_back(8'($urandom_range(0, 255)));
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin
    wrp_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (predicted_out_q.size() == 0) begin
        $error("result item with nothing predicted, payload_byte 0x%0h", payload_byte_o);
        error_count++;
      end else begin
        want = predicted_out_q.pop_front();
        check_field("payload_byte", 32'(want.payload_byte), 32'(payload_byte_o));
        check_field("is_payload", 32'(want.is_payload), 32'(is_payload_o));
        check_field("summary_valid", 32'(want.summary_valid), 32'(summary_valid_o));
        check_field("status", 32'(want.status), 32'(status_o));
        check_field("format_code", 32'(want.format_code), 32'(format_code_o));
        check_field("channel_count", 32'(want.channel_count), 32'(channel_count_o));
        check_field("rate_hz", want.rate_hz, rate_hz_o);
        check_field("sample_bits", 32'(want.sample_bits), 32'(sample_bits_o));
        check_field("is_u8", 32'(want.is_u8), 32'(is_u8_o));
        check_field("payload_length", want.payload_length, payload_length_o);
      end
    end
  end

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else begin
      out_ready_i <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $error("no item moved for %0d cycles", IDLE_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic test_header_checks();
    // short file: ends inside the header
    file_q.push_back(RIFF_MAGIC[0]);
    file_q.push_back(RIFF_MAGIC[1]);
    file_q.push_back(8'h00);
    send_file();
    file_q.push_back(8'hFF);
    send_file();
    // bad first magic: the valid chunks that follow are ignored
    push_riff_header();
    file_q[0] = 8'h72;
    push_fmt(16, FORMAT_PCM, 2, 44100, 16);
    push_chunk(TAG_DATA, 2);
    send_file();
    // bad second magic
    push_riff_header();
    file_q[11] = 8'h00;
    push_fmt(16, FORMAT_PCM, 1, 8000, 8);
    send_file();
  endtask

  task automatic test_pcm_files();
    push_riff_header();
    push_fmt(16, FORMAT_PCM, 2, 44100, 16);
    push_chunk(TAG_DATA, 5);
    push_le(32'hFF00_FF00, 4);
    send_file();
    push_riff_header();
    push_fmt(16, FORMAT_PCM, 16'hFFFF, 32'hFFFF_FFFF, BITS_U8);
    push_chunk(TAG_DATA, 4);
    send_file();
  endtask

  task automatic test_status_codes();
    // data but no fmt
    push_riff_header();
    push_chunk(TAG_DATA, 3);
    send_file();
    // fmt but no data
    push_riff_header();
    push_fmt(16, FORMAT_PCM, 1, 22050, 16);
    send_file();
    // data body cut short
    push_riff_header();
    push_fmt(16, FORMAT_PCM, 1, 22050, 16);
    push_tag(TAG_DATA);
    push_le(10, 4);
    push_le(32'h1234_5678, 4);
    send_file();
    // float format is not PCM
    push_riff_header();
    push_fmt(16, 16'd3, 2, 48000, 16'd32);
    push_chunk(TAG_DATA, 2);
    send_file();
  endtask

  task automatic test_fmt_shapes();
    // short fmt: missing bytes read as zero
    push_riff_header();
    push_fmt(6, FORMAT_PCM, 2, 32'hAABB_CCDD, 16);
    push_chunk(TAG_DATA, 1);
    send_file();
    // long fmt with odd size and pad
    push_riff_header();
    push_fmt(21, FORMAT_PCM, 1, 11025, 8);
    push_chunk(TAG_DATA, 2);
    send_file();
    // zero size fmt and zero size data complete at once
    push_riff_header();
    push_fmt(0, FORMAT_PCM, 1, 1, 1);
    push_chunk(TAG_DATA, 0);
    send_file();
    // second fmt cut short: the first one stays
    push_riff_header();
    push_fmt(16, FORMAT_PCM, 2, 96000, 24);
    push_chunk(32'h4C495354, 3);
    push_fmt(16, 16'd2, 6, 8000, 8);
    repeat (6) void'(file_q.pop_back());
    send_file();
    // chunk header cut short
    push_riff_header();
    push_fmt(16, FORMAT_PCM, 1, 8000, 8);
    push_tag(TAG_DATA);
    push_le(8, 1);
    send_file();
  endtask

  task automatic test_chunk_walk();
    // several data chunks before fmt; length comes from the last one
    push_riff_header();
    push_chunk(TAG_DATA, 3);
    push_chunk(32'h6A756E6B, 5);
    push_chunk(TAG_DATA, 2);
    push_fmt(16, FORMAT_PCM, 1, 16000, 16);
    push_le(32'h5555_AAAA, 4);
    send_file();
    // two complete fmt chunks: the later one wins
    push_riff_header();
    push_fmt(16, 16'd3, 4, 12345, 32);
    push_fmt(18, FORMAT_PCM, 1, 8000, 8);
    push_chunk(TAG_DATA, 1);
    send_file();
  endtask

  task automatic build_random_file();
    int nchunks;
    int pick;
    int i;
    int cut;
    logic [31:0] size;
    logic [15:0] code;
    logic [15:0] bits;
    if ($urandom_range(0, 99) < 10) begin
      repeat ($urandom_range(1, 24)) file_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    push_riff_header();
    if ($urandom_range(0, 9) == 0) begin
      i = $urandom_range(0, 11);
      file_q[i] = file_q[i] ^ 8'($urandom_range(1, 255));
    end
    nchunks = $urandom_range(0, 5);
    for (i = 0; i < nchunks; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        size = ($urandom_range(0, 1) != 0) ? 32'd16 : 32'($urandom_range(0, 24));
        code = ($urandom_range(0, 9) < 7) ? FORMAT_PCM : 16'($urandom);
        bits = ($urandom_range(0, 1) != 0) ? BITS_U8 :
               (($urandom_range(0, 2) != 0) ? 16'd16 : 16'($urandom));
        push_fmt(size, code, 16'($urandom), $urandom, bits);
      end else if (pick < 7) begin
        push_chunk(TAG_DATA, $urandom_range(0, 12));
      end else if (pick < 9) begin
        push_chunk($urandom, $urandom_range(0, 9));
      end else begin
        // huge size: the file ends inside this body
        push_tag(($urandom_range(0, 1) != 0) ? TAG_DATA : 32'($urandom));
        push_le($urandom | 32'h8000_0000, 4);
        repeat ($urandom_range(0, 6)) file_q.push_back(8'($urandom_range(0, 255)));
        break;
      end
    end
    if ($urandom_range(0, 9) < 3) begin
      repeat ($urandom_range(1, 6)) file_q.push_back(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 3) == 0) begin
      cut = $urandom_range(1, file_q.size());
      while (file_q.size() > cut) void'(file_q.pop_back());
    end
  endtask

  task automatic test_random_files();
    int bytes_sent;
    bytes_sent = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      build_random_file();
      allow_gaps = ($urandom_range(0, 3) != 0);
      bytes_sent += file_q.size();
      send_file();
    end
    allow_gaps = 1'b1;
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_byte_i    = '0;
    final_byte_i = 1'b0;
    out_ready_i  = 1'b0;
    clear_parser();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_header_checks();
    test_pcm_files();
    test_status_codes();
    test_fmt_shapes();
    test_chunk_walk();
    test_random_files();

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (predicted_out_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (predicted_out_q.size() != 0) begin
      $error("%0d result items never arrived", predicted_out_q.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
